>>> src/smt_decode_queue_arbiter_core_macros.svh
// Assertion macros for the decode queue arbiter.
`ifndef SMT_DECODE_QUEUE_ARBITER_CORE_MACROS_SVH
`define SMT_DECODE_QUEUE_ARBITER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SDQ_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SDQ_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> expr) else $error(msg);
`else
`define SDQ_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SDQ_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

>>> src/sdq_pkg.sv
// Types and constants shared by the decode queue arbiter.
package sdq_pkg;
    localparam int unsigned NUM_CTX_MAX = 4;
    localparam logic [0:0]  MODE_PUSH = 1'b0;
    localparam logic [0:0]  MODE_TICK = 1'b1;
    localparam logic [0:0]  REG_DECODE_WIDTH = 1'b0;
    localparam logic [0:0]  REG_TOTAL_LIMIT  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [1:0]  push_context;
        logic [15:0] push_inst_id;
        logic [3:0]  push_weight;
        logic [3:0]  active_mask;
        logic [3:0]  ideal_mask;
        logic [3:0]  downstream_stall_mask;
    } t_in_item;

    typedef struct packed {
        logic        inst_valid;
        logic [15:0] out_inst_id;
        logic [1:0]  out_context;
        logic        blocked;
        logic [3:0]  stall_mask;
        logic        overflow;
        logic        last;
    } t_out_item;

    // Request to the divider.
    typedef struct packed {
        logic       start;
        logic [7:0] dividend;
        logic [2:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
    } t_div_rsp;
endpackage

>>> src/sdq_div.sv
// Bit-serial restoring divider for the per-context queue limit.
module sdq_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sdq_pkg::t_div_req i_req,
    output sdq_pkg::t_div_rsp o_rsp
);
    import sdq_pkg::*;

    logic [7:0] r_quo, n_quo;
    logic [3:0] r_rem, n_rem;
    logic [2:0] r_den;
    logic [3:0] r_cnt, n_cnt;
    logic       r_busy, r_done;
    logic [4:0] trial;

    always_comb begin
        trial = {r_rem, r_quo[7]};
        n_quo = {r_quo[6:0], 1'b0};
        n_rem = trial[3:0];
        if (trial >= {2'b00, r_den}) begin
            n_rem = 4'(trial - {2'b00, r_den});
            n_quo[0] = 1'b1;
        end
        n_cnt = r_cnt - 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd8;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= n_cnt;
                if (n_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

>>> src/smt_decode_queue_arbiter_core.sv
// Top level of the multithreaded decode queue arbiter.
// Channels: input items on i_in_valid/o_in_stall with payload i_in; result
// items on o_out_valid/i_out_stall with payload o_out. Registers are
// written through i_cfg_we/i_cfg_idx/i_cfg_data.
// A push (mode 0) stores one instruction in its context's FIFO and gives
// one result marked last, with overflow set if the item was dropped; the
// result is registered in the push state once the output is free.
// A tick (mode 1) scans one context a cycle round-robin, then pops head
// instructions (up to decode_width, capped at MAX_WIDTH, summed weight);
// each pop runs through head read, check and result. The stall mask is
// then found by summing counts, dividing in the bit-serial divider and
// comparing; the final result carries last. With no active non-ideal
// context the divide and compare are skipped. A blocked tick answers
// at the end of the scan.
// The block takes one item at a time; o_in_stall stays high while one is
// at work. A stalled result holds in the output register and the
// sequencer waits. Reset clears queue pointers, counts, round-robin and
// stall bits; queue memory is not cleared and needs no clearing pass.
module smt_decode_queue_arbiter_core #(
    parameter int CONTEXTS    = 4,
    parameter int QUEUE_DEPTH = 32,
    parameter int MAX_WIDTH   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sdq_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sdq_pkg::t_out_item o_out,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data
);
    import sdq_pkg::*;
`include "smt_decode_queue_arbiter_core_macros.svh"

    localparam int CW   = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW   = $clog2(QUEUE_DEPTH + 1);
    localparam int MEMD = CONTEXTS * QUEUE_DEPTH;
    localparam int AW   = $clog2(MEMD);
    localparam int CMAX = (CONTEXTS < NUM_CTX_MAX) ? CONTEXTS : NUM_CTX_MAX;
    localparam int TW   = NW + 3;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PUSH  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_POP   = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_MASK  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_RDW   = 4'd9;

    logic [15:0] r_mem_id [MEMD];
    logic [3:0]  r_mem_w  [MEMD];
    logic [15:0] r_rd_id;
    logic [3:0]  r_rd_w;

    logic [QW-1:0] r_head [CONTEXTS];
    logic [NW-1:0] r_cnt  [CONTEXTS];
    logic [CW-1:0] r_last_srv;
    logic [3:0]    r_own_stall;
    logic [3:0]    r_dec_width;
    logic [7:0]    r_total_lim;

    logic [3:0]    r_state;
    t_in_item      r_item;
    logic [CW-1:0] r_ctx;
    logic [CW:0]   r_step;
    logic [4:0]    r_used;
    logic [TW-1:0] r_total;
    logic [2:0]    r_nctx;
    logic [7:0]    r_per;
    logic [3:0]    r_stall;
    logic          r_out_valid;
    t_out_item     r_out;

    t_div_req div_req;
    t_div_rsp div_rsp;

    sdq_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    logic          out_free;
    logic          out_load;
    logic [CW:0]   scan_sum;
    logic [CW-1:0] scan_ctx;
    logic          scan_ok;
    logic [CW-1:0] step_ctx;
    logic          step_ctx_ok;
    logic [3:0]    width_eff;
    logic [4:0]    used_next;
    logic [31:0]   push_sum;
    logic [AW-1:0] push_addr, head_addr;
    logic [CW-1:0] push_ctx;
    logic          push_ok;
    logic [3:0]    push_w;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A result register loads in these states once the output is free.
    assign out_load = out_free && ((r_state == S_PUSH) || (r_state == S_POP)
                   || (r_state == S_EMIT)
                   || ((r_state == S_SCAN) && !scan_ok && (32'(r_step) >= CONTEXTS)));

    assign width_eff = (r_dec_width > 4'(MAX_WIDTH > 15 ? 15 : MAX_WIDTH))
                     ? 4'(MAX_WIDTH > 15 ? 15 : MAX_WIDTH) : r_dec_width;
    assign used_next = r_used + {1'b0, r_rd_w};

    // Candidate for this scan step: one context a cycle, r_step past the last served.
    always_comb begin
        scan_sum = {1'b0, r_last_srv} + r_step;
        scan_ctx = (32'(scan_sum) >= CONTEXTS) ? CW'(32'(scan_sum) - CONTEXTS)
                                               : CW'(scan_sum);
        scan_ok  = (32'(scan_ctx) < CMAX) && r_item.active_mask[2'(scan_ctx)]
                && !(r_own_stall[2'(scan_ctx)] || r_item.downstream_stall_mask[2'(scan_ctx)]);
        step_ctx    = CW'(r_step);
        step_ctx_ok = (32'(r_step) < CMAX) && r_item.active_mask[2'(step_ctx)]
                   && !r_item.ideal_mask[2'(step_ctx)];
    end

    assign push_ok   = (32'(r_item.push_context) < CONTEXTS)
                    && (32'(r_cnt[CW'(r_item.push_context)]) < QUEUE_DEPTH);
    assign push_ctx  = CW'(r_item.push_context);
    assign push_sum  = 32'(r_head[push_ctx]) + 32'(r_cnt[push_ctx]);
    assign push_addr = AW'(32'(push_ctx) * QUEUE_DEPTH
                     + ((push_sum >= QUEUE_DEPTH) ? push_sum - QUEUE_DEPTH : push_sum));
    assign head_addr = AW'(32'(r_ctx) * QUEUE_DEPTH + 32'(r_head[r_ctx]));
    assign push_w    = (r_item.push_weight == 4'd0) ? 4'd1 : r_item.push_weight;

    always_comb begin
        div_req.start    = (r_state == S_SUM) && (32'(r_step) >= CMAX) && (r_nctx != 3'd0);
        div_req.dividend = r_total_lim;
        div_req.divisor  = r_nctx;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && push_ok) begin
            r_mem_id[push_addr] <= r_item.push_inst_id;
            r_mem_w[push_addr]  <= push_w;
        end
        r_rd_id <= r_mem_id[head_addr];
        r_rd_w  <= r_mem_w[head_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_srv  <= '0;
            r_own_stall <= '0;
            r_dec_width <= 4'd4;
            r_total_lim <= 8'd32;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CONTEXTS; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_DECODE_WIDTH) r_dec_width <= i_cfg_data[3:0];
                else r_total_lim <= i_cfg_data;
            end
            if (out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in;
                        r_step <= (CW+1)'(1);
                        r_state <= (i_in.mode == MODE_PUSH) ? S_PUSH : S_SCAN;
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        if (push_ok) r_cnt[push_ctx] <= NW'(r_cnt[push_ctx] + 1'b1);
                        r_out <= '{inst_valid: 1'b0, out_inst_id: '0,
                                   out_context: r_item.push_context, blocked: 1'b0,
                                   stall_mask: r_own_stall, overflow: !push_ok,
                                   last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (scan_ok) begin
                        r_ctx      <= scan_ctx;
                        r_last_srv <= scan_ctx;
                        r_used     <= '0;
                        r_state    <= S_RDW;
                    end else if (32'(r_step) >= CONTEXTS) begin
                        if (out_free) begin
                            r_out <= '{inst_valid: 1'b0, out_inst_id: '0,
                                       out_context: 2'd0, blocked: 1'b1,
                                       stall_mask: r_own_stall, overflow: 1'b0,
                                       last: 1'b1};
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_RDW: r_state <= S_RD;   // head address settles, read registered
                S_RD: begin
                    if (r_cnt[r_ctx] == '0 || used_next > {1'b0, width_eff}) begin
                        r_step  <= '0;
                        r_nctx  <= '0;
                        r_total <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (out_free) begin
                        r_out <= '{inst_valid: 1'b1, out_inst_id: r_rd_id,
                                   out_context: 2'(r_ctx), blocked: 1'b0,
                                   stall_mask: 4'd0, overflow: 1'b0, last: 1'b0};
                        r_head[r_ctx] <= (32'(r_head[r_ctx]) + 1 >= QUEUE_DEPTH)
                                       ? '0 : QW'(r_head[r_ctx] + 1'b1);
                        r_cnt[r_ctx]  <= NW'(r_cnt[r_ctx] - 1'b1);
                        r_used        <= used_next;
                        r_state       <= S_RDW;
                    end
                end
                S_SUM: begin
                    // Accumulate one context a cycle.
                    if (32'(r_step) < CMAX) begin
                        if (step_ctx_ok) begin
                            r_nctx  <= r_nctx + 3'd1;
                            r_total <= r_total + TW'(r_cnt[step_ctx]);
                        end
                        r_step <= r_step + 1'b1;
                    end else if (r_nctx == 3'd0) begin
                        r_stall <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_per   <= div_rsp.quotient;
                        r_step  <= '0;
                        r_stall <= '0;
                        r_state <= S_MASK;
                    end
                end
                S_MASK: begin
                    if (32'(r_step) < CMAX) begin
                        if (step_ctx_ok && ((TW'(r_cnt[step_ctx]) >= TW'(r_per))
                                || (r_total >= TW'(r_total_lim))))
                            r_stall[2'(step_ctx)] <= 1'b1;
                        r_step <= r_step + 1'b1;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out <= '{inst_valid: 1'b0, out_inst_id: '0,
                                   out_context: 2'(r_ctx), blocked: 1'b0,
                                   stall_mask: r_stall, overflow: 1'b0, last: 1'b1};
                        r_own_stall <= r_stall;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SDQ_ASSERT_IMPL(a_held_out, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)), "result changed while stalled")
    `SDQ_ASSERT_NEXT(a_busy_stall, i_clk, i_rst_n, (r_state != S_IDLE), o_in_stall || (r_state == S_IDLE), "input taken while busy")
    `SDQ_ASSERT_IMPL(a_inst_not_last, i_clk, i_rst_n, (o_out_valid && o_out.inst_valid) |-> !o_out.last, "decoded result marked last")
    `SDQ_ASSERT_IMPL(a_blocked_keeps, i_clk, i_rst_n, (o_out_valid && o_out.blocked) |-> (o_out.stall_mask == r_own_stall), "blocked tick changed stall mask")
endmodule

>>> tb/smt_decode_queue_arbiter_core_tb.sv
// Self-checking testbench for the decode queue arbiter: predicts every result item and compares.
module smt_decode_queue_arbiter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sdq_pkg::*;

    localparam int NCTX = 4;
    localparam int DEPTH = 32;
    localparam int WMAX = 8;
    localparam int IDLE_LIMIT = 20000;

    int errors = 0;

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    class decode_scoreboard;
        logic [15:0] ids[NCTX][DEPTH];
        logic [3:0]  wts[NCTX][DEPTH];
        int unsigned head[NCTX];
        int unsigned count[NCTX];
        logic [1:0]  last_ctx;
        logic [3:0]  stall_bits;
        logic [3:0]  width_reg;
        logic [7:0]  limit_reg;
        t_out_item   pending[$];

        function void clear();
            foreach (head[c]) begin
                head[c] = 0;
                count[c] = 0;
            end
            last_ctx = 0;
            stall_bits = 0;
            width_reg = 4;
            limit_reg = 32;
            pending.delete();
        endfunction

        function void add_expect(t_out_item r);
            pending.insert(pending.size(), r);
        endfunction

        function void write_reg(logic [0:0] idx, logic [7:0] val);
            if (idx == REG_DECODE_WIDTH) width_reg = val[3:0];
            else limit_reg = val;
        endfunction

        function void note_item(t_in_item it);
            t_out_item r;
            int unsigned c, slot, w, used, n, total, per;
            logic [1:0] pick;
            logic [3:0] stall;
            bit found;
            r = '0;
            used = 0;
            n = 0;
            total = 0;
            stall = 0;
            found = 0;
            pick = 0;
            if (it.mode == MODE_PUSH) begin
                c = it.push_context;
                r.overflow = 1;
                if (count[c] < DEPTH) begin
                    slot = (head[c] + count[c]) % DEPTH;
                    ids[c][slot] = it.push_inst_id;
                    wts[c][slot] = (it.push_weight == 0) ? 4'd1 : it.push_weight;
                    count[c]++;
                    r.overflow = 0;
                end
                r.out_context = it.push_context;
                r.stall_mask = stall_bits;
                r.last = 1;
                add_expect(r);
                return;
            end
            for (int off = 1; off <= NCTX; off++) begin
                c = (last_ctx + off) % NCTX;
                if (!found && it.active_mask[c] && !(stall_bits[c] | it.downstream_stall_mask[c])) begin
                    found = 1;
                    pick = c;
                end
            end
            if (!found) begin
                r.blocked = 1;
                r.stall_mask = stall_bits;
                r.last = 1;
                add_expect(r);
                return;
            end
            last_ctx = pick;
            w = (width_reg > WMAX) ? WMAX : width_reg;
            while (used < w && count[pick] > 0 && used + wts[pick][head[pick]] <= w) begin
                r = '0;
                r.inst_valid = 1;
                r.out_inst_id = ids[pick][head[pick]];
                r.out_context = pick;
                add_expect(r);
                used += wts[pick][head[pick]];
                head[pick] = (head[pick] + 1) % DEPTH;
                count[pick]--;
            end
            for (c = 0; c < NCTX; c++)
                if (it.active_mask[c] && !it.ideal_mask[c]) begin
                    n++;
                    total += count[c];
                end
            if (n > 0) begin
                per = limit_reg / n;
                for (c = 0; c < NCTX; c++)
                    if (it.active_mask[c] && !it.ideal_mask[c]
                        && (count[c] >= per || total >= limit_reg))
                        stall[c] = 1;
            end
            stall_bits = stall;
            r = '0;
            r.out_context = pick;
            r.stall_mask = stall;
            r.last = 1;
            add_expect(r);
        endfunction

        function string check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) return $sformatf("unexpected result %h", got);
            e = pending.pop_front();
            if (got.inst_valid != e.inst_valid || got.out_inst_id != e.out_inst_id
                || got.out_context != e.out_context || got.blocked != e.blocked
                || got.stall_mask != e.stall_mask || got.overflow != e.overflow
                || got.last != e.last)
                return $sformatf("got %p expected %p", got, e);
            return "";
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    t_in_item in_item = '0;
    logic out_valid;
    logic out_stall = 0;
    t_out_item out_item;
    logic cfg_we = 0;
    logic [0:0] cfg_idx = REG_DECODE_WIDTH;
    logic [7:0] cfg_data = '0;

    decode_scoreboard sb = new();
    int idle_cycles = 0;
    bit stall_enable = 1;

    always #5 clk = ~clk;

    smt_decode_queue_arbiter_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // check results and toggle the receiver stall
    always @(posedge clk) begin
        string msg;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                msg = sb.check_result(out_item);
                if (msg != "") report_mismatch(msg);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            out_stall <= stall_enable && ($urandom_range(0, 3) == 0
                         || ($urandom_range(0, 40) == 0));
        end
    end

    always @(posedge clk)
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end

    // valid stays up after the last item until a gap, the next item or drain
    task automatic send_item(input t_in_item it);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        sb.note_item(it);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic t_in_item mk_push(logic [1:0] c, logic [15:0] id, logic [3:0] w);
        t_in_item it;
        it = '0;
        it.mode = MODE_PUSH;
        it.push_context = c;
        it.push_inst_id = id;
        it.push_weight = w;
        it.active_mask = 4'($urandom);
        it.ideal_mask = 4'($urandom);
        it.downstream_stall_mask = 4'($urandom);
        return it;
    endfunction

    function automatic t_in_item mk_tick(logic [3:0] act, logic [3:0] idl, logic [3:0] dn);
        t_in_item it;
        it = '0;
        it.mode = MODE_TICK;
        it.push_context = 2'($urandom);
        it.push_inst_id = 16'($urandom);
        it.push_weight = 4'($urandom);
        it.active_mask = act;
        it.ideal_mask = idl;
        it.downstream_stall_mask = dn;
        return it;
    endfunction

    function automatic t_in_item rand_item();
        if ($urandom_range(0, 9) < 6)
            return mk_push(2'($urandom), 16'($urandom),
                           ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 3)));
        return mk_tick(($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF,
                       4'($urandom), ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'h0);
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) send_item(rand_item());
    endtask

    initial begin
        sb.clear();
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, zero weight, oversized head, blocked, overflow
        send_item(mk_push(0, 16'h0000, 4'd0));
        send_item(mk_push(0, 16'hFFFF, 4'd15));
        send_item(mk_push(1, 16'hA5A5, 4'd8));
        send_item(mk_push(3, 16'h5A5A, 4'd1));
        send_item(mk_tick(4'h0, 4'h0, 4'h0));
        send_item(mk_tick(4'hF, 4'h0, 4'hF));
        send_item(mk_tick(4'h1, 4'h0, 4'h0));
        send_item(mk_tick(4'hF, 4'hF, 4'h0));
        send_item(mk_tick(4'hF, 4'h0, 4'h0));
        for (int i = 0; i < 34; i++) send_item(mk_push(2, 16'(i), 4'd1));
        send_item(mk_tick(4'hF, 4'h3, 4'h0));
        drain();

        write_reg(REG_DECODE_WIDTH, 8'd15);
        write_reg(REG_TOTAL_LIMIT, 8'd0);
        send_item(mk_tick(4'h4, 4'h0, 4'h0));
        send_item(mk_tick(4'hF, 4'hF, 4'h0));
        drain();
        write_reg(REG_DECODE_WIDTH, 8'd0);
        write_reg(REG_TOTAL_LIMIT, 8'd255);
        send_item(mk_tick(4'hF, 4'h0, 4'h0));
        drain();

        write_reg(REG_DECODE_WIDTH, 8'd8);
        write_reg(REG_TOTAL_LIMIT, 8'd128);
        random_phase(15);
        drain();
        write_reg(REG_DECODE_WIDTH, 8'd1);
        write_reg(REG_TOTAL_LIMIT, 8'd1);
        random_phase(15);
        drain();
        write_reg(REG_DECODE_WIDTH, 8'd4);
        write_reg(REG_TOTAL_LIMIT, 8'd32);
        stall_enable = 0;
        random_phase(10);
        stall_enable = 1;
        random_phase(10);

        drain();
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
